>>> rtl/eat_pkg.sv
// Shared types and constants of the encoder angle tracker.
package eat_pkg;

   localparam int COUNTER_BITS = 16;
   localparam int ANGLE_W      = 16;
   localparam int TIME_W       = 32;
   localparam int MOD_W        = 17;
   localparam int CSR_DATA_W   = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int DELTA_W      = ((COUNTER_BITS > MOD_W) ? COUNTER_BITS : MOD_W) + 2;
   localparam int PROD_W       = DELTA_W + ANGLE_W + 1;
   localparam int SUM_W        = PROD_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_WINDOW = 2'd0,
      CSR_COUNTER_MODULUS = 2'd1,
      CSR_ANGLE_STEP      = 2'd2,
      CSR_ANGLE_MAX       = 2'd3
   } csr_index_type;

   localparam logic [15:0]        DEBOUNCE_RESET = 16'd50;
   localparam logic [MOD_W-1:0]   MODULUS_RESET  = 17'd40;
   localparam logic [ANGLE_W-1:0] STEP_RESET     = 16'd2304;
   localparam logic [ANGLE_W-1:0] MAX_RESET      = 16'd46080;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET    = 16'd23040;

   typedef struct packed {
      logic [15:0]        debounce_window_ms;
      logic [MOD_W-1:0]   counter_modulus;
      logic [ANGLE_W-1:0] angle_step;
      logic [ANGLE_W-1:0] angle_max;
   } cfg_type;

   typedef struct packed {
      logic enabled;
      logic toggled;
   } mode_type;

endpackage

>>> rtl/eat_if.sv
// Request and response channel interfaces of the encoder angle tracker.
interface eat_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        button_level;
   logic [15:0] counter_value;

   modport source (output valid, output now_ms, output button_level,
                   output counter_value, input ready);
   modport sink (input valid, input now_ms, input button_level,
                 input counter_value, output ready);
endinterface

interface eat_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] angle;
   logic        enabled;
   logic        mode_toggled;

   modport source (output valid, output angle, output enabled,
                   output mode_toggled, input ready);
   modport sink (input valid, input angle, input enabled,
                 input mode_toggled, output ready);
endinterface

>>> rtl/eat_debounce.sv
// Button debouncer and enable-mode toggle.
module eat_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [eat_pkg::TIME_W-1:0] now_ms,
   input  logic                      button_level,
   input  logic [15:0]               debounce_window_ms,
   output eat_pkg::mode_type         mode
);
   import eat_pkg::*;

   logic              raw_last_ff, raw_last_in;
   logic              debounced_ff, debounced_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic              enabled_ff, enabled_in;
   logic [TIME_W-1:0] elapsed;
   logic              accept_level;

   always_comb begin
      raw_last_in    = button_level;
      change_time_in = (button_level != raw_last_ff) ? now_ms : change_time_ff;
      elapsed        = now_ms - change_time_in;
      accept_level   = (elapsed >= {16'd0, debounce_window_ms}) &&
                       (button_level != debounced_ff);
      debounced_in   = accept_level ? button_level : debounced_ff;
      mode.toggled   = accept_level && !button_level;
      enabled_in     = enabled_ff ^ mode.toggled;
      mode.enabled   = enabled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff    <= 1'b1;
         debounced_ff   <= 1'b1;
         change_time_ff <= '0;
         enabled_ff     <= 1'b0;
      end else if (step) begin
         raw_last_ff    <= raw_last_in;
         debounced_ff   <= debounced_in;
         change_time_ff <= change_time_in;
         enabled_ff     <= enabled_in;
      end
   end

endmodule

>>> rtl/eat_angle.sv
// Encoder delta wrap, scaling and clamped angle accumulation.
module eat_angle (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  eat_pkg::mode_type                mode,
   input  logic [eat_pkg::COUNTER_BITS-1:0] counter_value,
   input  eat_pkg::cfg_type                 cfg,
   output logic [eat_pkg::ANGLE_W-1:0]      angle_next
);
   import eat_pkg::*;

   logic [COUNTER_BITS-1:0] last_count_ff, last_count_in;
   logic [ANGLE_W-1:0]      angle_ff, angle_in;
   logic signed [DELTA_W-1:0] delta_raw, delta, half, modulus;
   logic signed [PROD_W-1:0]  product;
   logic signed [SUM_W-1:0]   sum;

   always_comb begin
      modulus   = $signed(DELTA_W'(cfg.counter_modulus));
      half      = $signed(DELTA_W'(cfg.counter_modulus >> 1));
      delta_raw = $signed(DELTA_W'(counter_value)) - $signed(DELTA_W'(last_count_ff));
      // The two corrections are exclusive, so one of them at most applies.
      if (delta_raw > half) begin
         delta = delta_raw - modulus;
      end else if (delta_raw < -half) begin
         delta = delta_raw + modulus;
      end else begin
         delta = delta_raw;
      end
      product = PROD_W'(delta * $signed({1'b0, cfg.angle_step}));
      sum     = SUM_W'(product) + $signed(SUM_W'(angle_ff));

      if (mode.enabled) begin
         last_count_in = counter_value;
         if (sum < 0) begin
            angle_in = '0;
         end else if (sum > $signed(SUM_W'(cfg.angle_max))) begin
            angle_in = cfg.angle_max;
         end else begin
            angle_in = sum[ANGLE_W-1:0];
         end
      end else begin
         last_count_in = last_count_ff;
         angle_in      = angle_ff;
      end
      angle_next = angle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         angle_ff      <= ANGLE_RESET;
      end else if (step) begin
         last_count_ff <= last_count_in;
         angle_ff      <= angle_in;
      end
   end

endmodule

>>> rtl/encoder_angle_tracker.sv
// Top level of the encoder angle tracker: input stage, update logic and result stage.
//
// Usage: each request on req_bus carries a millisecond time stamp, the raw
// push-button level and the encoder counter reading. Every request yields
// exactly one response on rsp_bus with the accumulated angle (1/256 degree),
// the current enable mode and a flag that is high when this request toggled
// the mode through a debounced button press.
// On acceptance the request is captured in an input register, then the
// debounce and angle update run in one combinational pass into the
// response register, which drives response valid.
// Throughput is one request per clock cycle unless the receiver stalls;
// the state update (delta wrap, one 19 by 17 bit multiply, clamp) is combinational.
// When the receiver stalls, the response register holds its value and the
// input register fills; req_bus.ready falls only when both are occupied.
// Synchronous reset empties both stages, restores the register defaults
// (window 50 ms, modulus 40, step 2304, max 46080) and sets the angle to
// 90 degrees with the mode disabled.
// Configuration writes on csr_we take effect on the next processed request
// and are expected only while the block holds no request.
module encoder_angle_tracker (
   input  logic                            clock,
   input  logic                            reset,
   eat_req_if.sink                         req_bus,
   eat_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [eat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [eat_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import eat_pkg::*;

   cfg_type cfg_ff;

   // Input stage.
   logic                    in_valid_ff;
   logic [TIME_W-1:0]       in_now_ff;
   logic                    in_level_ff;
   logic [COUNTER_BITS-1:0] in_count_ff;

   // Response stage.
   logic               out_valid_ff;
   logic [ANGLE_W-1:0] out_angle_ff;
   logic               out_enabled_ff;
   logic               out_toggled_ff;

   logic               advance;
   logic               step;
   mode_type           mode;
   logic [ANGLE_W-1:0] angle_next;

   // The whole pipe moves when the response slot is free or being taken.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign step          = advance && in_valid_ff;
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_window_ms <= DEBOUNCE_RESET;
         cfg_ff.counter_modulus    <= MODULUS_RESET;
         cfg_ff.angle_step         <= STEP_RESET;
         cfg_ff.angle_max          <= MAX_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_WINDOW: cfg_ff.debounce_window_ms <= csr_wdata[15:0];
            CSR_COUNTER_MODULUS: cfg_ff.counter_modulus    <= csr_wdata;
            CSR_ANGLE_STEP:      cfg_ff.angle_step         <= csr_wdata[15:0];
            CSR_ANGLE_MAX:       cfg_ff.angle_max          <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_now_ff   <= req_bus.now_ms;
         in_level_ff <= req_bus.button_level;
         in_count_ff <= COUNTER_BITS'(req_bus.counter_value);
      end
   end

   eat_debounce u_debounce (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .now_ms             (in_now_ff),
      .button_level       (in_level_ff),
      .debounce_window_ms (cfg_ff.debounce_window_ms),
      .mode               (mode)
   );

   eat_angle u_angle (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .mode          (mode),
      .counter_value (in_count_ff),
      .cfg           (cfg_ff),
      .angle_next    (angle_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_angle_ff   <= angle_next;
         out_enabled_ff <= mode.enabled;
         out_toggled_ff <= mode.toggled;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.angle        = out_angle_ff;
   assign rsp_bus.enabled      = out_enabled_ff;
   assign rsp_bus.mode_toggled = out_toggled_ff;

endmodule

>>> sim/encoder_angle_checker.sv
// Response checker for the encoder angle tracker: predicts every response and compares it.
module encoder_angle_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [eat_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                             req_button_level,
   input  logic [eat_pkg::COUNTER_BITS-1:0] req_counter_value,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [eat_pkg::ANGLE_W-1:0]      rsp_angle,
   input  logic                             rsp_enabled,
   input  logic                             rsp_mode_toggled,
   input  logic                             csr_we,
   input  logic [eat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [eat_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               checked_count,
   output int                               toggle_count
);
   import eat_pkg::*;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               enabled;
      logic               toggled;
   } angle_result_type;

   localparam int REPORT_LIMIT = 10;

   // Private copy of the register file and of the tracker state.
   cfg_type                 cfg;
   logic                    raw_last;
   logic                    debounced_level;
   logic [TIME_W-1:0]       change_time;
   logic                    mode_enabled;
   logic [COUNTER_BITS-1:0] last_count;
   logic [ANGLE_W-1:0]      angle_acc;

   angle_result_type expected_angles[$];

   task automatic predict_angle_update(input logic [TIME_W-1:0] now_ms, input logic level,
                                       input logic [COUNTER_BITS-1:0] count,
                                       output angle_result_type res);
      logic [TIME_W-1:0] elapsed;
      longint            delta;
      longint            modulus;
      longint            half;
      longint            acc;
      logic              toggled;
      toggled = 1'b0;
      if (level != raw_last) begin
         change_time = now_ms;
         raw_last    = level;
      end
      elapsed = now_ms - change_time;
      if (elapsed >= TIME_W'(cfg.debounce_window_ms) && level != debounced_level) begin
         debounced_level = level;
         if (!level) begin
            mode_enabled = ~mode_enabled;
            toggled      = 1'b1;
         end
      end
      // While disabled the stored count is frozen, so the first enabled
      // request measures its delta against the old count.
      if (mode_enabled) begin
         delta   = longint'(count) - longint'(last_count);
         modulus = longint'(cfg.counter_modulus);
         half    = modulus / 2;
         if (delta > half) delta = delta - modulus;
         if (delta < -half) delta = delta + modulus;
         last_count = count;
         acc = longint'(angle_acc) + delta * longint'(cfg.angle_step);
         if (acc < 0) acc = 0;
         if (acc > longint'(cfg.angle_max)) acc = longint'(cfg.angle_max);
         angle_acc = ANGLE_W'(acc);
      end
      res.angle   = angle_acc;
      res.enabled = mode_enabled;
      res.toggled = toggled;
   endtask

   always @(posedge clock) begin
      angle_result_type predicted;
      angle_result_type wanted;
      angle_result_type seen;
      if (reset) begin
         cfg.debounce_window_ms = DEBOUNCE_RESET;
         cfg.counter_modulus    = MODULUS_RESET;
         cfg.angle_step         = STEP_RESET;
         cfg.angle_max          = MAX_RESET;
         raw_last               = 1'b1;
         debounced_level        = 1'b1;
         change_time            = '0;
         mode_enabled           = 1'b0;
         last_count             = '0;
         angle_acc              = ANGLE_RESET;
         expected_angles.delete();
         fail_count    = 0;
         checked_count = 0;
         toggle_count  = 0;
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DEBOUNCE_WINDOW: cfg.debounce_window_ms = csr_wdata[15:0];
               CSR_COUNTER_MODULUS: cfg.counter_modulus = csr_wdata[MOD_W-1:0];
               CSR_ANGLE_STEP:      cfg.angle_step = csr_wdata[ANGLE_W-1:0];
               CSR_ANGLE_MAX:       cfg.angle_max = csr_wdata[ANGLE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{angle: rsp_angle, enabled: rsp_enabled, toggled: rsp_mode_toggled};
            if (expected_angles.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("MISMATCH: response with no request outstanding: angle=%0d "
                           , seen.angle, "enabled=%0b toggled=%0b", seen.enabled,
                           seen.toggled);
            end else begin
               wanted = expected_angles.pop_front();
               checked_count++;
               if (seen != wanted) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("MISMATCH at response %0d: angle exp %0d got %0d, ",
                              checked_count, wanted.angle, seen.angle,
                              "enabled exp %0b got %0b, toggled exp %0b got %0b",
                              wanted.enabled, seen.enabled, wanted.toggled, seen.toggled);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_angle_update(req_now_ms, req_button_level, req_counter_value, predicted);
            if (predicted.toggled) toggle_count++;
            expected_angles.push_back(predicted);
         end
         pending_count <= expected_angles.size();
      end
   end

endmodule

>>> sim/tb.sv
// Testbench top for the encoder angle tracker: stimulus, register phases and verdict.
module tb;
   import eat_pkg::*;

   localparam int RESET_CYCLES = 7;
   // The block moves a request through its input and response registers and
   // the receiver stalls at random, so no handshake up to this limit means a hang.
   localparam int STALL_LIMIT  = 5000;
   // Two pipeline stages; the final drain catches any stray response.
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS  = 80;
   localparam int PHASES       = 4;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   eat_req_if req_bus();
   eat_rsp_if rsp_bus();

   int fail_count;
   int pending_count;
   int checked_count;
   int toggle_count;

   int send_idle_pct = 6;
   int recv_idle_pct = 47;
   int idle_cycles   = 0;
   int requests_sent = 0;
   int settings_used = 0;

   // State of the random stimulus: a running millisecond clock, the encoder
   // position, the level the "finger" wants and a count of bounce requests.
   logic [31:0] stim_ms;
   logic [15:0] stim_count;
   logic        stim_goal;
   int          bounce_left;
   int          cur_window;
   int          cur_modulus;

   encoder_angle_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   encoder_angle_checker angle_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_now_ms        (req_bus.now_ms),
      .req_button_level  (req_bus.button_level),
      .req_counter_value (req_bus.counter_value),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_angle         (rsp_bus.angle),
      .rsp_enabled       (rsp_bus.enabled),
      .rsp_mode_toggled  (rsp_bus.mode_toggled),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .toggle_count      (toggle_count)
   );

   always #5 clock = ~clock;

   // The receiver drops ready at random in the share of cycles that the
   // current idling pattern asks for.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_count);
         $display("Verification failed");
         $finish;
      end
   end

   // Presents one request, possibly after some idle cycles, and returns at
   // the edge where it is accepted. Valid stays high afterwards so that
   // back-to-back requests need no extra assignment in the same step.
   task automatic send_request(input logic [31:0] now_ms, input logic level,
                               input logic [15:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.now_ms        <= now_ms;
      req_bus.button_level  <= level;
      req_bus.counter_value <= count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
   endtask

   // Stops the request stream and waits until every response has come
   // back. The first edge is always waited so that a request accepted in
   // the current step is already counted as outstanding.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Registers are only rewritten while the tracker holds no request.
   task automatic apply_settings(input int window, input int modulus, input int step,
                                 input int max_angle);
      wait_idle();
      write_register(CSR_DEBOUNCE_WINDOW, CSR_DATA_W'(window));
      write_register(CSR_COUNTER_MODULUS, CSR_DATA_W'(modulus));
      write_register(CSR_ANGLE_STEP, CSR_DATA_W'(step));
      write_register(CSR_ANGLE_MAX, CSR_DATA_W'(max_angle));
      csr_we      <= 1'b0;
      cur_window  = window;
      cur_modulus = modulus;
      settings_used++;
   endtask

   // Picks a register setting, leaning toward the extremes. Modulus values
   // of zero and one and values above the counter range are included on
   // purpose, since the wrap correction behaves differently there.
   task automatic random_settings();
      int window;
      int modulus;
      int step;
      int max_angle;
      case ($urandom_range(4))
         0:       window = 0;
         1:       window = 65535;
         2:       window = $urandom_range(1, 8);
         default: window = $urandom_range(10, 300);
      endcase
      case ($urandom_range(7))
         0:       modulus = 0;
         1:       modulus = 1;
         2:       modulus = 2;
         3:       modulus = 65536;
         4:       modulus = $urandom_range(65537, 131071);
         5:       modulus = $urandom_range(3, 64);
         default: modulus = $urandom_range(2, 65536);
      endcase
      case ($urandom_range(4))
         0:       step = 0;
         1:       step = 65535;
         2:       step = $urandom_range(1, 64);
         default: step = $urandom_range(0, 4000);
      endcase
      case ($urandom_range(4))
         0:       max_angle = 0;
         1:       max_angle = 65535;
         2:       max_angle = $urandom_range(0, 2000);
         default: max_angle = $urandom_range(0, 65535);
      endcase
      apply_settings(window, modulus, step, max_angle);
   endtask

   // One random request. Most requests model a real user: time advances
   // in steps scaled to the debounce window so that presses are held long
   // enough to be accepted, each press or release may bounce for a few
   // requests, and the encoder turns a few counts at a time within its
   // period. A small share jumps time or the counter anywhere.
   task automatic random_request();
      logic [31:0] dt;
      logic        level;
      int          roll;
      int          delta;
      int          span;
      int          next_count;
      roll = $urandom_range(99);
      if (roll < 4)
         dt = $urandom;
      else if (roll < 15)
         dt = $urandom_range(0, 2);
      else
         dt = $urandom_range(1, cur_window / 3 + 2);
      if (bounce_left > 0) begin
         level = $urandom_range(1);
         bounce_left--;
         dt = $urandom_range(0, cur_window / 8 + 1);
      end else begin
         if ($urandom_range(99) < 12) begin
            stim_goal   = ~stim_goal;
            bounce_left = $urandom_range(0, 3);
         end
         level = stim_goal;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         stim_count = $urandom;
      end else begin
         if (roll < 20) begin
            span  = (cur_modulus >= 2 && cur_modulus <= 65536) ? cur_modulus / 2 : 32768;
            delta = int'($urandom_range(0, span));
            if ($urandom_range(1)) delta = -delta;
         end else begin
            delta = int'($urandom_range(16)) - 8;
         end
         if (cur_modulus >= 2 && cur_modulus <= 65536) begin
            next_count = (int'(stim_count) + delta) % cur_modulus;
            if (next_count < 0) next_count = next_count + cur_modulus;
         end else begin
            next_count = int'(stim_count) + delta;
         end
         stim_count = 16'(next_count);
      end
      stim_ms = stim_ms + dt;
      send_request(stim_ms, level, stim_count);
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.now_ms        = '0;
      req_bus.button_level  = 1'b1;
      req_bus.counter_value = '0;
      rsp_bus.ready         = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_DEBOUNCE_WINDOW;
      csr_wdata             = '0;
      stim_ms               = 32'd1000;
      stim_count            = '0;
      stim_goal             = 1'b1;
      bounce_left           = 0;
      cur_window            = int'(DEBOUNCE_RESET);
      cur_modulus           = int'(MODULUS_RESET);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset defaults. While disabled, the counter
      // is ignored, even at its extremes.
      send_request(32'd0, 1'b1, 16'd0);
      send_request(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      // A press that bounces back, then a press held one millisecond short
      // of the window and finally exactly the window: that one enables.
      send_request(32'd10, 1'b0, 16'd5);
      send_request(32'd40, 1'b1, 16'd5);
      send_request(32'd45, 1'b0, 16'd5);
      send_request(32'd94, 1'b0, 16'd5);
      send_request(32'd95, 1'b0, 16'd5);
      send_request(32'd96, 1'b0, 16'd6);
      // Counter jumps far beyond half the modulus: corrected only once,
      // then clamped at the top and at zero.
      send_request(32'd97, 1'b0, 16'hFFFF);
      send_request(32'd98, 1'b0, 16'd0);
      // Wrap across the counter period in both directions, then a delta of
      // exactly half the modulus, which is left as it is.
      send_request(32'd99, 1'b0, 16'd39);
      send_request(32'd100, 1'b0, 16'd1);
      send_request(32'd101, 1'b0, 16'd21);
      // Release is debounced as a rising edge and does not toggle.
      send_request(32'd102, 1'b1, 16'd21);
      send_request(32'd152, 1'b1, 16'd21);
      // A press whose stability time spans the wrap of the millisecond tick.
      send_request(32'hFFFF_FFF0, 1'b0, 16'd21);
      send_request(32'h0000_0021, 1'b0, 16'd30);
      send_request(32'h0000_0022, 1'b0, 16'd30);
      send_request(32'h0000_0030, 1'b0, 16'd35000);

      // Zero window accepts a level at once; a zero modulus never corrects.
      apply_settings(0, 0, 65535, 65535);
      send_request(32'd40, 1'b1, 16'd35000);
      send_request(32'd40, 1'b0, 16'd35000);
      send_request(32'd41, 1'b0, 16'd0);
      // A modulus of one corrects by a single count in each direction.
      apply_settings(0, 1, 1, 100);
      send_request(32'd42, 1'b0, 16'd200);
      send_request(32'd43, 1'b1, 16'd200);
      send_request(32'd44, 1'b0, 16'd200);
      // Max lowered below the stored angle: a disabled request keeps the
      // angle, the next enabled one clamps it.
      apply_settings(0, 1, 0, 10);
      send_request(32'd45, 1'b0, 16'd7);
      send_request(32'd46, 1'b1, 16'd7);
      send_request(32'd47, 1'b0, 16'd7);

      // Random part in three idling patterns, each over several settings.
      for (int seg = 0; seg < 3; seg++) begin
         case (seg)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int phase = 0; phase < PHASES; phase++) begin
            random_settings();
            repeat (PHASE_ITEMS) random_request();
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d checked responses over %0d register settings,",
               requests_sent, checked_count, settings_used);
      $display("with %0d mode toggles and three sender and receiver idling patterns.",
               toggle_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches found", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/eat_pkg.sv
rtl/eat_if.sv
rtl/eat_debounce.sv
rtl/eat_angle.sv
rtl/encoder_angle_tracker.sv
sim/encoder_angle_checker.sv
sim/tb.sv
